[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define BC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/bc_pkg.sv]
// ----------------------------------------------------------------------------
// Backlash compensation package
// Shared types and constants for the front end, queue and back end.
// ----------------------------------------------------------------------------
package bc_pkg;

  // Number of axis slots carried on the ports.
  localparam int AXIS_SLOTS = 6;
  localparam int POS_W      = 32;
  localparam int BL_W       = 16;
  localparam int TAG_W      = 24;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 3;

  // Depth of the queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_MASK = 3'd6;

  // Result kinds.
  localparam logic MOVE_CMD  = 1'b0;
  localparam logic MOVE_COMP = 1'b1;

  // Saturation limits.
  localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_INIT   = 2'd1,
    OP_LOAD   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef logic [AXIS_SLOTS-1:0][POS_W-1:0] pos_vec_t;
  typedef logic [AXIS_SLOTS-1:0][BL_W-1:0]  backlash_vec_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_t              op;
    pos_vec_t         pos;
    logic [TAG_W-1:0] tag;
  } q_entry_t;

  // One result item.
  typedef struct packed {
    logic             kind;
    pos_vec_t         pos;
    logic [TAG_W-1:0] tag;
    logic             last;
  } result_t;

  // Handshake status between the queue and its two neighbors.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

[src/bc_front.sv]
// ----------------------------------------------------------------------------
// Backlash compensation front end
// Accepts input transfers, decodes the operation, clears the positions of
// inactive axes and pushes the item into the queue.
// ----------------------------------------------------------------------------
module bc_front import bc_pkg::*; #(
  parameter int NUM_AXES = 3
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  pos_vec_t         in_pos,
  input  logic [TAG_W-1:0] in_line_tag,
  input  q_status_t        q_status,
  output logic             push,
  output q_entry_t         entry
);

  localparam logic [AXIS_SLOTS-1:0] ACTIVE_MASK =
    AXIS_SLOTS'((7'd1 << NUM_AXES) - 7'd1);

  op_t op;

  // Decode the operation code.
  always_comb begin
    case (in_operation)
      OP_MOVE: op = OP_MOVE;
      OP_INIT: op = OP_INIT;
      OP_LOAD: op = OP_LOAD;
      default: op = OP_UNUSED;
    endcase
  end

  // Build the queue entry; inactive axes always read as zero.
  always_comb begin
    entry.op  = op;
    entry.tag = in_line_tag;
    for (int i = 0; i < AXIS_SLOTS; i++) begin
      entry.pos[i] = ACTIVE_MASK[i] ? in_pos[i] : '0;
    end
  end

  // An unused operation is taken and dropped without a queue slot.
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready && (op != OP_UNUSED);

endmodule

[src/bc_queue.sv]
// ----------------------------------------------------------------------------
// Backlash compensation queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module bc_queue import bc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  `include "assert_macros.svh"

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == FULL_CNT);

  `BC_ASSERT(a_count_range, count_r <= FULL_CNT, "queue count beyond depth")
  `BC_ASSERT_IMPL(a_no_underflow, pop, count_r != '0, "pop from empty queue")
  `BC_ASSERT_IMPL(a_no_overflow, push, count_r != FULL_CNT, "push into full queue")

endmodule

[src/bc_back.sv]
// ----------------------------------------------------------------------------
// Backlash compensation back end
// Holds the previous positions and direction flags, detects reversals,
// applies the saturated backlash shift and emits one or two results per move.
// ----------------------------------------------------------------------------
module bc_back import bc_pkg::*; #(
  parameter int NUM_AXES = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  backlash_vec_t     backlash,
  input  logic [MASK_W-1:0] homing_mask,
  input  q_entry_t          head,
  input  q_status_t         q_status,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_result
);

  `include "assert_macros.svh"

  localparam logic [AXIS_SLOTS-1:0] ACTIVE_MASK =
    AXIS_SLOTS'((7'd1 << NUM_AXES) - 7'd1);

  pos_vec_t               prev_r, prev_nxt;
  logic [AXIS_SLOTS-1:0]  neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r, out_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  result_t                pend_r, pend_nxt;

  logic [AXIS_SLOTS-1:0]  en, rev_up, rev_dn;
  logic [AXIS_SLOTS-1:0][POS_W:0] shifted;
  pos_vec_t               comp_pos;
  logic                   any_en, comp;
  logic                   out_free;
  result_t                cmd_res, comp_res;

  // Per-axis reversal detection and saturated backlash shift.
  always_comb begin
    for (int i = 0; i < AXIS_SLOTS; i++) begin
      en[i]     = ACTIVE_MASK[i] && (backlash[i] != '0);
      rev_up[i] = en[i] && neg_r[i] &&
                  ($signed(head.pos[i]) > $signed(prev_r[i]));
      rev_dn[i] = en[i] && !neg_r[i] &&
                  ($signed(head.pos[i]) < $signed(prev_r[i]));
      if (rev_up[i]) begin
        shifted[i] = {prev_r[i][POS_W-1], prev_r[i]} + {{(POS_W-BL_W+1){1'b0}}, backlash[i]};
      end else begin
        shifted[i] = {prev_r[i][POS_W-1], prev_r[i]} - {{(POS_W-BL_W+1){1'b0}}, backlash[i]};
      end
      if (!(rev_up[i] || rev_dn[i])) begin
        comp_pos[i] = prev_r[i];
      end else if (shifted[i][POS_W] != shifted[i][POS_W-1]) begin
        comp_pos[i] = shifted[i][POS_W] ? POS_MIN : POS_MAX;
      end else begin
        comp_pos[i] = shifted[i][POS_W-1:0];
      end
    end
    any_en = |en;
    comp   = |(rev_up | rev_dn);
  end

  // The two possible results of a move.
  always_comb begin
    cmd_res.kind  = MOVE_CMD;
    cmd_res.pos   = head.pos;
    cmd_res.tag   = head.tag;
    cmd_res.last  = 1'b1;
    comp_res.kind = MOVE_COMP;
    comp_res.pos  = comp_pos;
    comp_res.tag  = head.tag;
    comp_res.last = 1'b0;
  end

  // An item is taken once the pending result has gone out and the output
  // register is free or is being emptied in this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign pop      = q_status.valid && out_free && !pend_valid_r;

  // State, output register and pending result.
  always_comb begin
    prev_nxt       = prev_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;

    if (out_free) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    if (pop) begin
      case (head.op)
        OP_MOVE: begin
          if (any_en) begin
            neg_nxt = (neg_r & ~rev_up) | rev_dn;
            for (int i = 0; i < AXIS_SLOTS; i++) begin
              if (ACTIVE_MASK[i]) begin
                prev_nxt[i] = head.pos[i];
              end
            end
          end
          out_valid_nxt = 1'b1;
          if (comp) begin
            out_nxt        = comp_res;
            pend_nxt       = cmd_res;
            pend_valid_nxt = 1'b1;
          end else begin
            out_nxt = cmd_res;
          end
        end
        OP_INIT: begin
          neg_nxt = ACTIVE_MASK ^ homing_mask;
          for (int i = 0; i < AXIS_SLOTS; i++) begin
            if (ACTIVE_MASK[i]) begin
              prev_nxt[i] = head.pos[i];
            end
          end
        end
        OP_LOAD: begin
          for (int i = 0; i < AXIS_SLOTS; i++) begin
            if (ACTIVE_MASK[i]) begin
              prev_nxt[i] = head.pos[i];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      neg_r        <= '1;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      prev_r       <= prev_nxt;
      neg_r        <= neg_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  `BC_ASSERT_IMPL(a_pend_needs_out, pend_valid_r, out_valid_r,
    "pending result without an occupied output register")
  `BC_ASSERT_IMPL(a_pend_is_cmd, pend_valid_r,
    (pend_r.kind == MOVE_CMD) && pend_r.last,
    "pending result is not the closing commanded move")
  `BC_ASSERT_IMPL(a_comp_not_last, out_valid_r && (out_r.kind == MOVE_COMP),
    !out_r.last && pend_valid_r,
    "compensation move without its commanded move behind it")

endmodule

[src/backlash_compensation.sv]
// Backlash compensation for up to six axes. Each input transfer carries an
// operation and six signed micrometre positions; a move whose axes reverse
// direction on an axis with nonzero backlash yields a rapid compensation move
// followed by the commanded move, any other move yields the commanded move
// alone, and init or load operations yield nothing. The front end takes one
// item per clock into a two-entry queue while the queue is not full; the back
// end retires one queued item per clock given a ready consumer, but takes no
// new item while the commanded move behind a compensation move is still
// pending, because the single output register delivers one result per clock.
// Backlash values and the homing mask are read live and are meant to be
// written while the block is idle.
// ----------------------------------------------------------------------------
// Backlash compensation top level
// Configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module backlash_compensation import bc_pkg::*; #(
  parameter int NUM_AXES = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BL_W-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic signed [31:0]   in_pos_axis0,
  input  logic signed [31:0]   in_pos_axis1,
  input  logic signed [31:0]   in_pos_axis2,
  input  logic signed [31:0]   in_pos_axis3,
  input  logic signed [31:0]   in_pos_axis4,
  input  logic signed [31:0]   in_pos_axis5,
  input  logic [TAG_W-1:0]     in_line_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_move_kind,
  output logic signed [31:0]   out_axis0,
  output logic signed [31:0]   out_axis1,
  output logic signed [31:0]   out_axis2,
  output logic signed [31:0]   out_axis3,
  output logic signed [31:0]   out_axis4,
  output logic signed [31:0]   out_axis5,
  output logic [TAG_W-1:0]     out_line_tag,
  output logic                 out_last
);

  backlash_vec_t     backlash_r;
  logic [MASK_W-1:0] homing_mask_r;

  pos_vec_t  in_pos;
  q_status_t q_status;
  q_entry_t  push_entry, head;
  logic      push, pop;
  result_t   result;

  // Configuration registers; indexes past the homing mask are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlash_r    <= '0;
      homing_mask_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HOMING_MASK) begin
        homing_mask_r <= cfg_wdata[MASK_W-1:0];
      end else if (cfg_index < CFG_HOMING_MASK) begin
        backlash_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  assign in_pos[0] = in_pos_axis0;
  assign in_pos[1] = in_pos_axis1;
  assign in_pos[2] = in_pos_axis2;
  assign in_pos[3] = in_pos_axis3;
  assign in_pos[4] = in_pos_axis4;
  assign in_pos[5] = in_pos_axis5;

  bc_front #(
    .NUM_AXES (NUM_AXES)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_pos       (in_pos),
    .in_line_tag  (in_line_tag),
    .q_status     (q_status),
    .push         (push),
    .entry        (push_entry)
  );

  bc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  bc_back #(
    .NUM_AXES (NUM_AXES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .backlash    (backlash_r),
    .homing_mask (homing_mask_r),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (result)
  );

  // Result fields onto their ports.
  assign out_move_kind = result.kind;
  assign out_axis0     = result.pos[0];
  assign out_axis1     = result.pos[1];
  assign out_axis2     = result.pos[2];
  assign out_axis3     = result.pos[3];
  assign out_axis4     = result.pos[4];
  assign out_axis5     = result.pos[5];
  assign out_line_tag  = result.tag;
  assign out_last      = result.last;

endmodule

[tb/sv/backlash_compensation_tb.sv]
// ----------------------------------------------------------------------------
// Backlash compensation testbench
// Drives move, init and load transfers into the block and predicts every
// result with a cycle-free model of the per-axis direction flags, stored
// positions and backlash registers. Results are checked field by field in
// order. Both sides idle at random, and one long receiver hold-off fills the
// block and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module backlash_compensation_tb;
  import bc_pkg::*;

  localparam int NUM_AXES = 3;
  localparam logic [MASK_W-1:0] ACTIVE_MASK = MASK_W'((1 << NUM_AXES) - 1);

  // Register indexes not named in the package.
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX     = 3'd7;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 250;
  localparam int NUM_PHASES     = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BL_W-1:0]      cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_operation = OP_MOVE;
  logic signed [31:0]   in_pos_axis0 = '0;
  logic signed [31:0]   in_pos_axis1 = '0;
  logic signed [31:0]   in_pos_axis2 = '0;
  logic signed [31:0]   in_pos_axis3 = '0;
  logic signed [31:0]   in_pos_axis4 = '0;
  logic signed [31:0]   in_pos_axis5 = '0;
  logic [TAG_W-1:0]     in_line_tag = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_move_kind;
  logic signed [31:0]   out_axis0;
  logic signed [31:0]   out_axis1;
  logic signed [31:0]   out_axis2;
  logic signed [31:0]   out_axis3;
  logic signed [31:0]   out_axis4;
  logic signed [31:0]   out_axis5;
  logic [TAG_W-1:0]     out_line_tag;
  logic                 out_last;

  backlash_compensation #(.NUM_AXES(NUM_AXES)) uut (.*);

  always #4 clk = ~clk;

  // Tracked copy of the block's registers and state.
  logic [BL_W-1:0]   trk_backlash [AXIS_SLOTS] = '{default: '0};
  logic [MASK_W-1:0] trk_home_mask = '0;
  int                trk_prev_pos [AXIS_SLOTS] = '{default: 0};
  logic [MASK_W-1:0] trk_neg_dir = '1;

  result_t pending_moves[$];
  int      cursor [AXIS_SLOTS] = '{default: 0};
  int      fail_count = 0;
  int      quiet_cycles = 0;
  bit      gaps_on = 1'b1;
  bit      hold_req = 1'b0;
  bit      holding = 1'b0;

  // Random idle length: mostly none, sometimes short, rarely long.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_pos(input longint v);
    if (v > longint'($signed(POS_MAX))) return $signed(POS_MAX);
    if (v < longint'($signed(POS_MIN))) return $signed(POS_MIN);
    return int'(v);
  endfunction

  // Next coordinate for one axis: mostly small steps either way from the
  // last one, so that reversals and equal targets are common.
  function automatic logic [31:0] pick_coord(input int axis);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) cursor[axis] = $signed(POS_MAX);
    else if (r < 4) cursor[axis] = $signed(POS_MIN);
    else if (r < 10) cursor[axis] = $urandom();
    else if (r >= 22) cursor[axis] = cursor[axis] + int'($urandom_range(0, 2000)) - 1000;
    return cursor[axis];
  endfunction

  function automatic logic [BL_W-1:0] pick_backlash(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (phase == 0) return '0;
    if (phase == 1) return '1;
    if (r < 30) return '0;
    if (r < 45) return '1;
    if (r < 70) return BL_W'($urandom_range(1, 64));
    return BL_W'($urandom());
  endfunction

  // Positions for the active axes; the inactive slots carry noise.
  function automatic pos_vec_t trio(input int a, input int b, input int c);
    pos_vec_t p;
    for (int i = 0; i < AXIS_SLOTS; i++) p[i] = $urandom();
    p[0] = a;
    p[1] = b;
    p[2] = c;
    return p;
  endfunction

  // Work out the results of one accepted transfer and update tracked state.
  task automatic predict_moves(input op_t op, input pos_vec_t target,
                               input logic [TAG_W-1:0] tag);
    logic    any_on;
    logic    reversed;
    result_t r;
    int      i;
    case (op)
      OP_INIT, OP_LOAD: begin
        if (op == OP_INIT) trk_neg_dir = ACTIVE_MASK ^ trk_home_mask;
        for (i = 0; i < NUM_AXES; i++) trk_prev_pos[i] = target[i];
      end
      OP_MOVE: begin
        any_on = 1'b0;
        reversed = 1'b0;
        for (i = 0; i < NUM_AXES; i++) if (trk_backlash[i] != 0) any_on = 1'b1;
        if (any_on) begin
          for (i = 0; i < NUM_AXES; i++) begin
            if (trk_backlash[i] == 0) continue;
            if ($signed(target[i]) > trk_prev_pos[i]) begin
              if (trk_neg_dir[i]) begin
                trk_neg_dir[i] = 1'b0;
                trk_prev_pos[i] = clamp_pos(longint'(trk_prev_pos[i]) +
                                            longint'(trk_backlash[i]));
                reversed = 1'b1;
              end
            end else if ($signed(target[i]) < trk_prev_pos[i] && !trk_neg_dir[i]) begin
              trk_neg_dir[i] = 1'b1;
              trk_prev_pos[i] = clamp_pos(longint'(trk_prev_pos[i]) -
                                          longint'(trk_backlash[i]));
              reversed = 1'b1;
            end
          end
          // The rapid move goes to the shifted stored positions.
          if (reversed) begin
            r = '0;
            r.kind = MOVE_COMP;
            for (i = 0; i < NUM_AXES; i++) r.pos[i] = trk_prev_pos[i];
            r.tag = tag;
            r.last = 1'b0;
            pending_moves.push_back(r);
          end
          for (i = 0; i < NUM_AXES; i++) trk_prev_pos[i] = target[i];
        end
        r = '0;
        r.kind = MOVE_CMD;
        for (i = 0; i < NUM_AXES; i++) r.pos[i] = target[i];
        r.tag = tag;
        r.last = 1'b1;
        pending_moves.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // Offer one item and hold it until the transfer, then idle at random.
  task automatic send_item(input op_t op, input pos_vec_t p, input logic [TAG_W-1:0] tag);
    int gap;
    in_valid <= 1'b1;
    in_operation <= op;
    in_pos_axis0 <= p[0];
    in_pos_axis1 <= p[1];
    in_pos_axis2 <= p[2];
    in_pos_axis3 <= p[3];
    in_pos_axis4 <= p[4];
    in_pos_axis5 <= p[5];
    in_line_tag <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_moves(op, p, tag);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BL_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < AXIS_SLOTS) trk_backlash[idx] = data;
    else if (idx == CFG_HOMING_MASK) trk_home_mask = data[MASK_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected result has arrived and the block has gone quiet.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Backlash only on inactive axes must leave moves untouched.
  task automatic test_passthrough();
    for (int i = NUM_AXES; i < AXIS_SLOTS; i++) begin
      write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + i), '1);
    end
    send_item(OP_MOVE, {AXIS_SLOTS{POS_MAX}}, '1);
    send_item(OP_MOVE, {AXIS_SLOTS{POS_MIN}}, '0);
    send_item(OP_INIT, '1, 24'h5A5A5A);
    send_item(OP_UNUSED, {AXIS_SLOTS{32'h1234_5678}}, 24'hA5A5A5);
    send_item(OP_MOVE, {AXIS_SLOTS{32'h5555_5555}}, 24'h0F0F0F);
    settle_idle();
  endtask

  // Reversals, equal targets, saturation in both directions, spare index.
  task automatic test_compensation();
    write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + 0), 16'd1);
    write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + 1), 16'hFFFF);
    write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + 2), 16'd100);
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    write_reg(CFG_HOMING_MASK, 16'h0005);
    send_item(OP_INIT, trio(0, 0, 0), 24'd1);
    send_item(OP_MOVE, trio(10, 10, 10), 24'd2);
    send_item(OP_MOVE, trio(10, 10, 10), 24'd3);
    send_item(OP_MOVE, trio(5, 5, 5), 24'd4);
    send_item(OP_LOAD, trio($signed(POS_MAX) - 16, $signed(POS_MAX) - 16,
                            $signed(POS_MIN) + 32), 24'd5);
    send_item(OP_MOVE, trio($signed(POS_MAX), $signed(POS_MAX),
                            $signed(POS_MIN) + 40), 24'd6);
    send_item(OP_MOVE, trio($signed(POS_MAX), $signed(POS_MAX), $signed(POS_MIN)), 24'd7);
    send_item(OP_UNUSED, trio(-1, -1, -1), 24'd8);
    send_item(OP_MOVE, trio(-1, 3, 0), 24'd9);
    settle_idle();
  endtask

  // Phases of random traffic, each under a fresh register setting.
  task automatic test_random_moves();
    op_t      op;
    pos_vec_t p;
    int       r;
    int       sent;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      for (int i = 0; i < AXIS_SLOTS; i++) begin
        write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + i), pick_backlash(ph));
      end
      write_reg(CFG_HOMING_MASK, BL_W'($urandom()));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_IDX, BL_W'($urandom()));
      gaps_on = (ph % 3) != 2;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        op = (r < 80) ? OP_MOVE : (r < 87) ? OP_INIT : (r < 94) ? OP_LOAD : OP_UNUSED;
        for (int i = 0; i < AXIS_SLOTS; i++) p[i] = pick_coord(i);
        send_item(op, p, TAG_W'($urandom_range(0, 24'hFFFFFF)));
        if (op != OP_UNUSED) sent++;
      end
    end
    gaps_on = 1'b1;
    settle_idle();
  endtask

  // The receiver holds off while moves keep coming, so the block backs up.
  task automatic test_backpressure();
    pos_vec_t p;
    write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + 0), 16'd50);
    write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + 1), 16'd1);
    write_reg(CFG_IDX_W'(CFG_BACKLASH_BASE + 2), 16'hFFFF);
    hold_req = 1'b1;
    while (!holding) @(posedge clk);
    gaps_on = 1'b0;
    repeat (40) begin
      for (int i = 0; i < AXIS_SLOTS; i++) p[i] = pick_coord(i);
      send_item(OP_MOVE, p, TAG_W'($urandom_range(0, 24'hFFFFFF)));
    end
    gaps_on = 1'b1;
    settle_idle();
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        hold_req = 1'b0;
      end
      n = next_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expected move.
  always @(posedge clk) begin : result_check
    result_t seen;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_move_kind, out_axis5, out_axis4, out_axis3, out_axis2, out_axis1,
              out_axis0, out_line_tag, out_last};
      if (pending_moves.size() == 0) begin
        $error("result with no move pending: move_kind %0d out_line_tag %0h",
               seen.kind, seen.tag);
        fail_count++;
      end else begin
        want = pending_moves.pop_front();
        if (seen.kind !== want.kind) begin
          $error("move_kind: expected %0d, actual %0d", want.kind, seen.kind);
          fail_count++;
        end
        for (int i = 0; i < AXIS_SLOTS; i++) begin
          if (seen.pos[i] !== want.pos[i]) begin
            $error("out_axis%0d: expected %0d, actual %0d", i, $signed(want.pos[i]),
                   $signed(seen.pos[i]));
            fail_count++;
          end
        end
        if (seen.tag !== want.tag) begin
          $error("out_line_tag: expected %0h, actual %0h", want.tag, seen.tag);
          fail_count++;
        end
        if (seen.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, seen.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_compensation();
    test_random_moves();
    test_backpressure();
    settle_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[backlash_compensation.f]
+incdir+src
src/bc_pkg.sv
src/bc_front.sv
src/bc_queue.sv
src/bc_back.sv
src/backlash_compensation.sv
tb/sv/backlash_compensation_tb.sv
